### rtl/rtc2ux_pkg.sv
`default_nettype none
package rtc2ux_pkg;

  // error codes, first failing check wins
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_OSC   = 3'd1;
  localparam logic [2:0] ERR_YEAR  = 3'd2;
  localparam logic [2:0] ERR_MONTH = 3'd3;
  localparam logic [2:0] ERR_DAY   = 3'd4;
  localparam logic [2:0] ERR_TIME  = 3'd5;
  localparam logic [2:0] ERR_MIN   = 3'd6;

  localparam logic [31:0] MIN_EPOCH_RESET = 32'd1704067200;

  // two-digit year window, years since 2000
  localparam logic [7:0] YEAR_LO = 8'd24;
  localparam logic [7:0] YEAR_HI = 8'd99;

  // all accepted years sit in era 5: 5 * 146097 - 719468, less one for day-1
  localparam logic [16:0] DAY_BASE = 17'd11016;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // decoded fields after the range checks
  typedef struct packed {
    logic [2:0] err;
    logic [6:0] yoe;
    logic [3:0] mp;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
  } dec_t;

  // day count and time of day
  typedef struct packed {
    logic [2:0]  err;
    logic [16:0] days;
    logic [16:0] tod;
    logic [2:0]  wday;
  } days_t;

  // raw epoch before the minimum check
  typedef struct packed {
    logic [2:0]  err;
    logic [31:0] epoch;
    logic [2:0]  wday;
  } ep_t;

  // final result
  typedef struct packed {
    logic        ok;
    logic [2:0]  err;
    logic [31:0] epoch;
    logic [2:0]  wday;
  } res_t;

  // two BCD digits to binary, no digit check
  function automatic logic [7:0] bcd2bin(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'd0, v[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
  endfunction

  // days from March 1 to the first of the shifted month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### rtl/rtc2ux_decode.sv
`default_nettype none
module rtc2ux_decode import rtc2ux_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       in_v,
  input  wire logic [7:0] seconds_reg,
  input  wire logic [7:0] minutes_reg,
  input  wire logic [7:0] hours_reg,
  input  wire logic [7:0] days_reg,
  input  wire logic [7:0] weekdays_reg,
  input  wire logic [7:0] months_reg,
  input  wire logic [7:0] years_reg,
  output logic            out_v,
  output dec_t            out_d
);

  logic [7:0] yy, mon, dd, hh, mm, ss;
  logic       early;
  dec_t       d_next;

  // mask and decode the BCD fields
  always_comb begin
    yy  = bcd2bin(years_reg);
    mon = bcd2bin({3'd0, months_reg[4:0]});
    dd  = bcd2bin({2'd0, days_reg[5:0]});
    hh  = bcd2bin({2'd0, hours_reg[5:0]});
    mm  = bcd2bin({1'b0, minutes_reg[6:0]});
    ss  = bcd2bin({1'b0, seconds_reg[6:0]});
  end

  // run the checks and shift the year to start in March
  always_comb begin
    early = (mon <= 8'd2);
    if (seconds_reg[7]) begin
      d_next.err = ERR_OSC;
    end else if (yy < YEAR_LO || yy > YEAR_HI) begin
      d_next.err = ERR_YEAR;
    end else if (mon < 8'd1 || mon > 8'd12) begin
      d_next.err = ERR_MONTH;
    end else if (dd < 8'd1 || dd > 8'd31) begin
      d_next.err = ERR_DAY;
    end else if (hh > 8'd23 || mm > 8'd59 || ss > 8'd59) begin
      d_next.err = ERR_TIME;
    end else begin
      d_next.err = ERR_NONE;
    end
    d_next.yoe    = yy[6:0] - {6'd0, early};
    d_next.mp     = early ? (mon[3:0] + 4'd9) : (mon[3:0] - 4'd3);
    d_next.day    = dd[4:0];
    d_next.hour   = hh[4:0];
    d_next.minute = mm[5:0];
    d_next.second = ss[5:0];
    d_next.wday   = weekdays_reg[2:0];
  end

  // advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rtc2ux_days.sv
`default_nettype none
module rtc2ux_days import rtc2ux_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_v,
  input  wire dec_t  in_d,
  output logic       out_v,
  output days_t      out_d
);

  logic [16:0] yoe_w;
  days_t       d_next;

  // day count since 1970 and seconds into the day
  always_comb begin
    yoe_w        = {10'd0, in_d.yoe};
    d_next.err   = in_d.err;
    d_next.days  = yoe_w * 17'd365 + (yoe_w >> 2)
                 + {8'd0, month_start(in_d.mp)} + {12'd0, in_d.day} + DAY_BASE;
    d_next.tod   = {12'd0, in_d.hour} * 17'd3600 + {11'd0, in_d.minute} * 17'd60
                 + {11'd0, in_d.second};
    d_next.wday  = in_d.wday;
  end

  // advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rtc2ux_epoch.sv
`default_nettype none
module rtc2ux_epoch import rtc2ux_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_v,
  input  wire days_t in_d,
  output logic       out_v,
  output ep_t        out_d
);

  logic [33:0] prod;
  ep_t         d_next;

  // scale days to seconds and add the time of day
  always_comb begin
    prod         = {17'd0, in_d.days} * {17'd0, SECS_PER_DAY} + {17'd0, in_d.tod};
    d_next.err   = in_d.err;
    d_next.epoch = prod[31:0];
    d_next.wday  = in_d.wday;
  end

  // advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rtc2ux_check.sv
`default_nettype none
module rtc2ux_check import rtc2ux_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_v,
  input  wire ep_t         in_d,
  input  wire logic [31:0] min_epoch,
  output logic             out_v,
  output res_t             out_d
);

  res_t d_next;

  // reject epochs below the minimum, zero the epoch on any error
  always_comb begin
    if (in_d.err == ERR_NONE && in_d.epoch < min_epoch) begin
      d_next.err = ERR_MIN;
    end else begin
      d_next.err = in_d.err;
    end
    d_next.ok    = (d_next.err == ERR_NONE);
    d_next.epoch = d_next.ok ? in_d.epoch : 32'd0;
    d_next.wday  = in_d.wday;
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule
`default_nettype wire

### rtl/bcd_rtc_to_unix_epoch_core.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   seconds_reg .. years_reg (7 x 8 bit)
// out       source     out_valid / out_stall ok, error_code, epoch_seconds, day_of_week
// cfg       sink       cfg_wen               cfg_wdata = min_valid_epoch
//
// Four register stages: decode and check, day count, seconds multiply, minimum check.
// An item enters every cycle unless in_stall is high; stages register it in order.
// Reset empties the pipeline and loads min_valid_epoch with 1704067200.
// Each stage moves when it is empty or the next stage moves; out_stall backs up the
// pipeline one stage at a time and in_stall rises only when all four stages are full.
module bcd_rtc_to_unix_epoch_core import rtc2ux_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  seconds_reg,
  input  wire logic [7:0]  minutes_reg,
  input  wire logic [7:0]  hours_reg,
  input  wire logic [7:0]  days_reg,
  input  wire logic [7:0]  weekdays_reg,
  input  wire logic [7:0]  months_reg,
  input  wire logic [7:0]  years_reg,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic [2:0]       error_code,
  output logic [31:0]      epoch_seconds,
  output logic [2:0]       day_of_week,
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] min_epoch;
  logic        v1, v2, v3, v4;
  logic        en1, en2, en3, en4;
  dec_t        d1;
  days_t       d2;
  ep_t         d3;
  res_t        d4;

  // write the minimum epoch register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_epoch <= MIN_EPOCH_RESET;
    end else if (cfg_wen) begin
      min_epoch <= cfg_wdata;
    end
  end

  // stage enables: load when empty or when the next stage moves
  assign en4 = !v4 || !out_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  rtc2ux_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .en           (en1),
    .in_v         (in_valid),
    .seconds_reg  (seconds_reg),
    .minutes_reg  (minutes_reg),
    .hours_reg    (hours_reg),
    .days_reg     (days_reg),
    .weekdays_reg (weekdays_reg),
    .months_reg   (months_reg),
    .years_reg    (years_reg),
    .out_v        (v1),
    .out_d        (d1)
  );

  rtc2ux_days u_days (
    .clk   (clk),
    .rst   (rst),
    .en    (en2),
    .in_v  (v1),
    .in_d  (d1),
    .out_v (v2),
    .out_d (d2)
  );

  rtc2ux_epoch u_epoch (
    .clk   (clk),
    .rst   (rst),
    .en    (en3),
    .in_v  (v2),
    .in_d  (d2),
    .out_v (v3),
    .out_d (d3)
  );

  rtc2ux_check u_check (
    .clk       (clk),
    .rst       (rst),
    .en        (en4),
    .in_v      (v3),
    .in_d      (d3),
    .min_epoch (min_epoch),
    .out_v     (v4),
    .out_d     (d4)
  );

  // drive the result ports
  assign out_valid     = v4;
  assign ok            = d4.ok;
  assign error_code    = d4.err;
  assign epoch_seconds = d4.epoch;
  assign day_of_week   = d4.wday;

  // a good result clears the minimum
  a_ok_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> epoch_seconds >= min_epoch && error_code == ERR_NONE)
    else $error("ok result below minimum epoch");

  // a failed result carries a zero epoch
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> epoch_seconds == 32'd0 && error_code != ERR_NONE)
    else $error("failed result with nonzero epoch");

  // input backs up only with a full pipeline behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && v4 && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

### verif/rtc_epoch_checker.sv
`timescale 1ns / 100ps
module rtc_epoch_checker import rtc2ux_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  seconds_reg,
  input  wire logic [7:0]  minutes_reg,
  input  wire logic [7:0]  hours_reg,
  input  wire logic [7:0]  days_reg,
  input  wire logic [7:0]  weekdays_reg,
  input  wire logic [7:0]  months_reg,
  input  wire logic [7:0]  years_reg,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        ok,
  input  wire logic [2:0]  error_code,
  input  wire logic [31:0] epoch_seconds,
  input  wire logic [2:0]  day_of_week,
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata,
  output int               failures,
  output int               pending
);

  logic [31:0] floor_epoch;
  res_t        pending_times[$];

  function automatic int unsigned bcd_to_int(input logic [7:0] v);
    return int'(v[7:4]) * 10 + int'(v[3:0]);
  endfunction

  // Decode the raw clock registers and convert to Unix seconds.
  function automatic res_t decode_rtc_time(input logic [7:0] sec_r, input logic [7:0] min_r,
                                           input logic [7:0] hr_r, input logic [7:0] day_r,
                                           input logic [7:0] wd_r, input logic [7:0] mon_r,
                                           input logic [7:0] yr_r, input logic [31:0] lower);
    longint unsigned year, month, mday, hour, minute, second;
    longint unsigned y, era, yoe, mp, doy, doe, days, secs;
    res_t r;
    r.err = ERR_NONE;
    secs = 0;
    year = bcd_to_int(yr_r) + 2000;
    month = bcd_to_int(mon_r & 8'h1F);
    mday = bcd_to_int(day_r & 8'h3F);
    hour = bcd_to_int(hr_r & 8'h3F);
    minute = bcd_to_int(min_r & 8'h7F);
    second = bcd_to_int(sec_r & 8'h7F);
    if (sec_r[7]) begin
      r.err = ERR_OSC;
    end else if (year < 2024 || year > 2099) begin
      r.err = ERR_YEAR;
    end else if (month < 1 || month > 12) begin
      r.err = ERR_MONTH;
    end else if (mday < 1 || mday > 31) begin
      r.err = ERR_DAY;
    end else if (hour > 23 || minute > 59 || second > 59) begin
      r.err = ERR_TIME;
    end else begin
      // days from civil, years counted from March
      y = (month <= 2) ? year - 1 : year;
      era = y / 400;
      yoe = y - era * 400;
      mp = (month > 2) ? month - 3 : month + 9;
      doy = (153 * mp + 2) / 5 + mday - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      secs = days * 86400 + hour * 3600 + minute * 60 + second;
      if (secs < longint'(lower)) begin
        r.err = ERR_MIN;
        secs = 0;
      end
    end
    r.ok = (r.err == ERR_NONE);
    r.epoch = secs[31:0];
    r.wday = wd_r[2:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    failures++;
  endtask

  initial begin
    failures = 0;
    pending = 0;
    floor_epoch = MIN_EPOCH_RESET;
  end

  // Track config, queue predictions, compare results at each edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      floor_epoch = MIN_EPOCH_RESET;
      pending_times.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_times.size() == 0) begin
          $display("[%0t] result with no item outstanding", $realtime);
          failures++;
        end else begin
          want = pending_times.pop_front();
          if (ok !== want.ok) flag_mismatch("ok", 32'(ok), 32'(want.ok));
          if (error_code !== want.err)
            flag_mismatch("error_code", 32'(error_code), 32'(want.err));
          if (epoch_seconds !== want.epoch)
            flag_mismatch("epoch_seconds", epoch_seconds, want.epoch);
          if (day_of_week !== want.wday)
            flag_mismatch("day_of_week", 32'(day_of_week), 32'(want.wday));
        end
      end
      if (in_valid && !in_stall)
        pending_times.push_back(decode_rtc_time(seconds_reg, minutes_reg, hours_reg,
                                                days_reg, weekdays_reg, months_reg,
                                                years_reg, floor_epoch));
      if (cfg_wen) floor_epoch = cfg_wdata;
    end
    pending = pending_times.size();
  end

endmodule

### verif/bcd_rtc_to_unix_epoch_core_tb.sv
`timescale 1ns / 100ps
module bcd_rtc_to_unix_epoch_core_tb import rtc2ux_pkg::*;;

  localparam logic [31:0] EPOCH_CEILING = 32'd4102444799;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] mins;
    logic [7:0] hrs;
    logic [7:0] mday;
    logic [7:0] wday;
    logic [7:0] mon;
    logic [7:0] yr;
  } rtc_regs_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  seconds_reg, minutes_reg, hours_reg, days_reg;
  logic [7:0]  weekdays_reg, months_reg, years_reg;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [2:0]  error_code;
  logic [31:0] epoch_seconds;
  logic [2:0]  day_of_week;
  logic        cfg_wen;
  logic [31:0] cfg_wdata;
  int          failures;
  int          pending;
  int          cycle_count;
  int          burst_left;
  bit          hold_req;
  bit          hold_done;

  bcd_rtc_to_unix_epoch_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .seconds_reg(seconds_reg), .minutes_reg(minutes_reg), .hours_reg(hours_reg),
    .days_reg(days_reg), .weekdays_reg(weekdays_reg), .months_reg(months_reg),
    .years_reg(years_reg),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .error_code(error_code), .epoch_seconds(epoch_seconds),
    .day_of_week(day_of_week),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  rtc_epoch_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .seconds_reg(seconds_reg), .minutes_reg(minutes_reg), .hours_reg(hours_reg),
    .days_reg(days_reg), .weekdays_reg(weekdays_reg), .months_reg(months_reg),
    .years_reg(years_reg),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .error_code(error_code), .epoch_seconds(epoch_seconds),
    .day_of_week(day_of_week),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic rtc_regs_t rtc(input logic [7:0] s, input logic [7:0] m,
                                    input logic [7:0] h, input logic [7:0] d,
                                    input logic [7:0] w, input logic [7:0] mo,
                                    input logic [7:0] y);
    rtc_regs_t r;
    r = '{sec: s, mins: m, hrs: h, mday: d, wday: w, mon: mo, yr: y};
    return r;
  endfunction

  // Legal time with random junk in the bits the decoder masks off.
  function automatic rtc_regs_t random_good_time();
    rtc_regs_t r;
    r.sec = to_bcd($urandom_range(59, 0));
    r.mins = to_bcd($urandom_range(59, 0)) | (8'($urandom_range(1, 0)) << 7);
    r.hrs = to_bcd($urandom_range(23, 0)) | (8'($urandom_range(3, 0)) << 6);
    r.mday = to_bcd($urandom_range(31, 1)) | (8'($urandom_range(3, 0)) << 6);
    r.wday = 8'($urandom_range(255, 0));
    r.mon = to_bcd($urandom_range(12, 1)) | (8'($urandom_range(7, 0)) << 5);
    r.yr = to_bcd($urandom_range(99, 24));
    return r;
  endfunction

  // Mostly legal times, some with one field corrupted, some pure noise.
  function automatic rtc_regs_t random_time();
    rtc_regs_t r;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    r = random_good_time();
    if (pick >= 90) begin
      r = rtc_regs_t'({$urandom(), $urandom()});
    end else if (pick >= 70) begin
      case ($urandom_range(6, 0))
        0: r.sec[7] = 1'b1;
        1: r.sec = 8'($urandom_range(127, 0));
        2: r.mins = 8'($urandom_range(255, 0));
        3: r.hrs = 8'($urandom_range(255, 0));
        4: r.mday = 8'($urandom_range(255, 0));
        5: r.mon = 8'($urandom_range(255, 0));
        default: r.yr = 8'($urandom_range(255, 0));
      endcase
    end
    return r;
  endfunction

  // Offer one item and hold it until accepted; gaps fall between bursts.
  task automatic send_time(input rtc_regs_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
      burst_left = ($urandom_range(4, 0) == 0) ? 60 : $urandom_range(20, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    seconds_reg <= r.sec;
    minutes_reg <= r.mins;
    hours_reg <= r.hrs;
    days_reg <= r.mday;
    weekdays_reg <= r.wday;
    months_reg <= r.mon;
    years_reg <= r.yr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and drain the pipeline before touching the config.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_floor(input logic [31:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random(input int count, input bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 40) hold_req = 1'b1;
      send_time(random_time());
    end
  endtask

  // Receiver: stall in segments of varying density, plus one long hold-off.
  initial begin
    int seg_len;
    int mode;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      seg_len = $urandom_range(60, 5);
      mode = $urandom_range(3, 0);
      for (int i = 0; i < seg_len; i++) begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
          out_stall <= 1'b1;
          for (int c = 0; c < 80; c++) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3, 0) == 0);
          2: out_stall <= ($urandom_range(3, 0) != 0);
          default: out_stall <= i[0];
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    {seconds_reg, minutes_reg, hours_reg, days_reg} = '0;
    {weekdays_reg, months_reg, years_reg} = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners under the reset floor
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h24));
    send_time(rtc(8'h59, 8'h59, 8'h23, 8'h31, 8'h03, 8'h12, 8'h99));
    send_time(rtc(8'h45, 8'h30, 8'h12, 8'h29, 8'h04, 8'h02, 8'h24));
    send_time(rtc(8'h10, 8'h20, 8'h08, 8'h31, 8'h05, 8'h02, 8'h25));
    send_time(rtc(8'h80, 8'h00, 8'h10, 8'h15, 8'h02, 8'h06, 8'h30));
    send_time(rtc(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_time(rtc(8'h59, 8'h59, 8'h23, 8'h31, 8'h06, 8'h12, 8'h23));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h9A));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h07, 8'h00, 8'h40));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h13, 8'h40));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h0A, 8'h40));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h05, 8'h40));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h05, 8'h40));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h1F, 8'h01, 8'h05, 8'h40));
    send_time(rtc(8'h00, 8'h00, 8'h24, 8'h10, 8'h01, 8'h05, 8'h40));
    send_time(rtc(8'h00, 8'h60, 8'h10, 8'h10, 8'h01, 8'h05, 8'h40));
    send_time(rtc(8'h5A, 8'h10, 8'h10, 8'h10, 8'h01, 8'h05, 8'h40));
    send_time(rtc(8'h33, 8'hC4, 8'hD9, 8'hE8, 8'hFF, 8'hE7, 8'h55));
    drain();

    // highest floor: only the last second of the window passes
    write_floor(EPOCH_CEILING);
    send_time(rtc(8'h59, 8'h59, 8'h23, 8'h31, 8'h02, 8'h12, 8'h99));
    send_time(rtc(8'h58, 8'h59, 8'h23, 8'h31, 8'h02, 8'h12, 8'h99));
    send_time(rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h24));
    drain();

    // floor at zero, with the long receiver hold-off
    write_floor(32'd0);
    send_random(ITEMS_PER_PHASE, 1'b1);
    drain();

    write_floor($urandom_range(EPOCH_CEILING, MIN_EPOCH_RESET));
    send_random(ITEMS_PER_PHASE, 1'b0);
    drain();

    write_floor(MIN_EPOCH_RESET);
    send_random(ITEMS_PER_PHASE, 1'b0);
    drain();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/rtc2ux_pkg.sv
rtl/rtc2ux_decode.sv
rtl/rtc2ux_days.sv
rtl/rtc2ux_epoch.sv
rtl/rtc2ux_check.sv
rtl/bcd_rtc_to_unix_epoch_core.sv
verif/rtc_epoch_checker.sv
verif/bcd_rtc_to_unix_epoch_core_tb.sv
